// ===== design/schedule_path_enumerator_assert.svh =====
// Assertion macros for the schedule path enumerator.
// Included by the top level; the bodies expect signals named clock and reset.
`ifndef SCHEDULE_PATH_ENUMERATOR_ASSERT_SVH
`define SCHEDULE_PATH_ENUMERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/spe_pkg.sv =====
// Shared types and constants of the schedule path enumerator.
// No dependencies; used by the top level through scoped names.
`default_nettype none

package spe_pkg;

   // Command codes carried in the cmd field of an input item.
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_YIELD  = 2'd1;
   localparam logic [1:0] CMD_INVAL  = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   // Fixed widths of the channel fields.
   localparam int CMD_W    = 2;
   localparam int CHOICE_W = 8;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [CHOICE_W-1:0] max_choice;
   } req_type;

   typedef struct packed {
      logic [CHOICE_W-1:0] choice;
      logic                all_done;
      logic                depth_overflow;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_YIELD,
      ST_WALK,
      ST_CLEAR,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== design/spe_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module spe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/spe_digit_unit.sv =====
// Shared digit unit: adds an optional one to an operand and compares the sum
// against a limit. Used for bound widening on yield and digit stepping on finish.
`default_nettype none

module spe_digit_unit #(
   parameter int CHOICE_BITS = 8
) (
   input  wire logic [CHOICE_BITS-1:0] operand,
   input  wire logic                   inc,
   input  wire logic [CHOICE_BITS-1:0] limit,
   output logic      [CHOICE_BITS:0]   sum,
   output logic                        over
);

   // One extra bit keeps the increment of an all-ones digit from wrapping.
   always_comb begin
      sum  = {1'b0, operand} + (CHOICE_BITS + 1)'(inc);
      over = sum > {1'b0, limit};
   end

endmodule

`default_nettype wire

// ===== design/schedule_path_enumerator.sv =====
// Schedule path enumerator: steps through every choice path of a repeated run as a
// mixed-radix odometer, one choice digit and one bound per step, held in two RAMs
// of MAX_STEPS entries. After reset a clearing pass zeroes both tables, and no item
// is taken meanwhile. One item is handled at a time. Start and invalidate go
// straight to the response; a yield at full depth does too, and a normal yield first
// reads the RAMs, then compares and updates the bound. A finish walks the carry
// through the digits and then clears any choices after the cut; a finish that
// records a deeper run clears the choice of every step of the new depth. The
// single write port of each RAM and the shared digit unit handle one digit per
// cycle. A result waits in an output register until taken.
// Depends on spe_pkg, spe_ram, spe_digit_unit and schedule_path_enumerator_assert.svh.
`default_nettype none

module schedule_path_enumerator #(
   parameter int MAX_STEPS   = 256,
   parameter int CHOICE_BITS = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire spe_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output spe_pkg::rsp_type     rsp_data
);

`include "schedule_path_enumerator_assert.svh"

   localparam int CW = CHOICE_BITS;
   localparam int AW = $clog2(MAX_STEPS);
   localparam int DW = $clog2(MAX_STEPS + 1);

   // Control registers.
   spe_pkg::state_type state_ff, state_in;
   logic [DW-1:0] idx_ff, idx_in;
   logic [DW-1:0] step_depth_ff, step_depth_in;
   logic [DW-1:0] deepest_ff, deepest_in;
   logic [DW-1:0] cut_ff, cut_in;
   logic          cut_valid_ff, cut_valid_in;
   logic          finished_ff, finished_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [CW-1:0]    offered_ff, offered_in;
   logic [CW-1:0]    res_choice_ff, res_choice_in;
   logic             res_ovf_ff, res_ovf_in;
   spe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // RAM and digit unit connections.
   logic          choice_we, bound_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [CW-1:0] choice_wdata;
   logic [CW-1:0] bound_wdata;
   logic [CW-1:0] choice_rd, bound_rd;
   logic [CW-1:0] unit_operand;
   logic          unit_inc;
   logic [CW:0]   unit_sum;
   logic          unit_over;

   // Derived control values.
   logic          req_fire;
   logic          rsp_free;
   logic          table_full;
   logic          deeper;
   logic [DW-1:0] cut_next;
   logic [DW-1:0] walk_start;
   logic          cut_clr_go;
   logic [15:0]   mc_ext;
   logic [15:0]   choice_ext;

   assign req_stall  = (state_ff != spe_pkg::ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign table_full = (step_depth_ff >= DW'(MAX_STEPS));
   assign deeper     = (step_depth_ff > deepest_ff);
   assign cut_next   = cut_ff + DW'(1);
   assign walk_start = cut_valid_ff ? cut_next : deepest_ff;
   assign cut_clr_go = cut_valid_ff && (cut_next < deepest_ff);
   assign mc_ext     = {8'd0, req_data.max_choice};
   assign choice_ext = 16'(res_choice_ff);

   // Choice digits and bounds, addressed together.
   spe_ram #(.WIDTH(CW), .DEPTH(MAX_STEPS)) u_choice_ram (
      .clock   (clock),
      .wr_en   (choice_we),
      .wr_addr (wr_addr),
      .wr_data (choice_wdata),
      .rd_addr (rd_addr),
      .rd_data (choice_rd)
   );

   spe_ram #(.WIDTH(CW), .DEPTH(MAX_STEPS)) u_bound_ram (
      .clock   (clock),
      .wr_en   (bound_we),
      .wr_addr (wr_addr),
      .wr_data (bound_wdata),
      .rd_addr (rd_addr),
      .rd_data (bound_rd)
   );

   // The yield compares the offered maximum with the bound; the walk steps a digit.
   assign unit_operand = (state_ff == spe_pkg::ST_YIELD) ? offered_ff : choice_rd;
   assign unit_inc     = (state_ff == spe_pkg::ST_WALK);

   spe_digit_unit #(.CHOICE_BITS(CW)) u_digit (
      .operand (unit_operand),
      .inc     (unit_inc),
      .limit   (bound_rd),
      .sum     (unit_sum),
      .over    (unit_over)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spe_pkg::ST_INIT: begin
            if (idx_ff == DW'(MAX_STEPS - 1)) begin
               state_in = spe_pkg::ST_IDLE;
            end
         end
         spe_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_data.cmd)
                  spe_pkg::CMD_YIELD: begin
                     state_in = table_full ? spe_pkg::ST_RESP : spe_pkg::ST_YIELD;
                  end
                  spe_pkg::CMD_FINISH: begin
                     if (deeper) begin
                        state_in = spe_pkg::ST_CLEAR;
                     end else if (walk_start != '0) begin
                        state_in = spe_pkg::ST_WALK;
                     end else begin
                        state_in = cut_clr_go ? spe_pkg::ST_CLEAR : spe_pkg::ST_RESP;
                     end
                  end
                  default: begin
                     state_in = spe_pkg::ST_RESP;
                  end
               endcase
            end
         end
         spe_pkg::ST_YIELD: begin
            state_in = spe_pkg::ST_RESP;
         end
         spe_pkg::ST_WALK: begin
            if (!(unit_over && (idx_ff != '0))) begin
               state_in = cut_clr_go ? spe_pkg::ST_CLEAR : spe_pkg::ST_RESP;
            end
         end
         spe_pkg::ST_CLEAR: begin
            if ((idx_ff + DW'(1)) >= deepest_ff) begin
               state_in = spe_pkg::ST_RESP;
            end
         end
         spe_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = spe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spe_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control and register updates for each state.
   always_comb begin
      idx_in        = idx_ff;
      step_depth_in = step_depth_ff;
      deepest_in    = deepest_ff;
      cut_in        = cut_ff;
      cut_valid_in  = cut_valid_ff;
      finished_in   = finished_ff;
      offered_in    = offered_ff;
      res_choice_in = res_choice_ff;
      res_ovf_in    = res_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      choice_we     = 1'b0;
      bound_we      = 1'b0;
      choice_wdata  = '0;
      bound_wdata   = offered_ff;
      wr_addr       = idx_ff[AW-1:0];
      rd_addr       = idx_ff[AW-1:0];

      case (state_ff)
         spe_pkg::ST_INIT: begin
            // Clearing pass over both tables after reset.
            choice_we   = 1'b1;
            bound_we    = 1'b1;
            bound_wdata = '0;
            idx_in      = idx_ff + DW'(1);
         end
         spe_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_choice_in = '0;
               res_ovf_in    = 1'b0;
               case (req_data.cmd)
                  spe_pkg::CMD_START: begin
                     cut_valid_in  = 1'b0;
                     cut_in        = '0;
                     step_depth_in = '0;
                  end
                  spe_pkg::CMD_YIELD: begin
                     res_ovf_in = table_full;
                     offered_in = mc_ext[CW-1:0];
                     rd_addr    = step_depth_ff[AW-1:0];
                  end
                  spe_pkg::CMD_INVAL: begin
                     if (!cut_valid_ff && (step_depth_ff != '0)) begin
                        cut_valid_in = 1'b1;
                        cut_in       = step_depth_ff - DW'(1);
                     end
                  end
                  spe_pkg::CMD_FINISH: begin
                     if (deeper) begin
                        // New deepest run: clear every choice below it.
                        deepest_in = step_depth_ff;
                        idx_in     = '0;
                     end else if (walk_start != '0) begin
                        idx_in  = walk_start - DW'(1);
                        rd_addr = idx_in[AW-1:0];
                     end else begin
                        // Nothing to step: the carry is left over.
                        finished_in = 1'b1;
                        idx_in      = cut_next;
                     end
                  end
                  default: begin
                     res_ovf_in = 1'b0;
                  end
               endcase
            end
         end
         spe_pkg::ST_YIELD: begin
            // Widen the bound when the offer exceeds it and return the digit.
            wr_addr       = step_depth_ff[AW-1:0];
            bound_we      = unit_over;
            res_choice_in = choice_rd;
            step_depth_in = step_depth_ff + DW'(1);
         end
         spe_pkg::ST_WALK: begin
            // One digit per cycle; the next lower digit is read meanwhile.
            choice_we    = 1'b1;
            choice_wdata = unit_over ? '0 : unit_sum[CW-1:0];
            if (unit_over && (idx_ff != '0)) begin
               idx_in  = idx_ff - DW'(1);
               rd_addr = idx_in[AW-1:0];
            end else begin
               if (unit_over) begin
                  finished_in = 1'b1;
               end
               idx_in = cut_next;
            end
         end
         spe_pkg::ST_CLEAR: begin
            choice_we = 1'b1;
            idx_in    = idx_ff + DW'(1);
         end
         spe_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.choice         = choice_ext[7:0];
               rsp_data_in.all_done       = finished_ff;
               rsp_data_in.depth_overflow = res_ovf_ff;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spe_pkg::ST_INIT;
         idx_ff        <= '0;
         step_depth_ff <= '0;
         deepest_ff    <= '0;
         cut_ff        <= '0;
         cut_valid_ff  <= 1'b0;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         step_depth_ff <= step_depth_in;
         deepest_ff    <= deepest_in;
         cut_ff        <= cut_in;
         cut_valid_ff  <= cut_valid_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      offered_ff    <= offered_in;
      res_choice_ff <= res_choice_in;
      res_ovf_ff    <= res_ovf_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer and the run state.
   `SPE_ASSERT_NEXT(a_done_sticky, finished_ff, finished_ff, "all_done flag was cleared")
   `SPE_ASSERT_NEXT(a_item_busy, req_fire, state_ff != spe_pkg::ST_IDLE, "item not taken up")
   `SPE_ASSERT_NOW(a_depth_range, 1'b1, step_depth_ff <= DW'(MAX_STEPS), "depth out of range")
   `SPE_ASSERT_NOW(a_cut_below_depth, cut_valid_ff, cut_ff < step_depth_ff, "cut past depth")
   `SPE_ASSERT_NOW(a_index_range,
      state_ff == spe_pkg::ST_WALK || state_ff == spe_pkg::ST_CLEAR,
      idx_ff < DW'(MAX_STEPS), "table index out of range")

endmodule

`default_nettype wire
